// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Simulation builds get checking
// assertions, and synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PS2KB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PS2KB_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PS2KB_ASSERT(lbl, clk, rst_n, prop, msg)
`define PS2KB_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

// ===== hdl/ps2kb_pkg.sv =====
package ps2kb_pkg;

    localparam int OP_W       = 2;
    localparam int BYTE_W     = 8;
    localparam int KEY_SLOTS  = 128;
    localparam int KEY_W      = $clog2(KEY_SLOTS);
    localparam int RETRY_W    = 4;

    localparam int QDEPTH     = 16;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = QPTR_W + 1;

    localparam int OUT_DEPTH  = 4;
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W  = OUT_PTR_W + 1;

    localparam logic [RETRY_W-1:0] MAX_RETRIES_RST = 4'd3;

    localparam logic [BYTE_W-1:0] ACK_BYTE    = 8'hFA;
    localparam logic [BYTE_W-1:0] RESEND_BYTE = 8'hFE;
    localparam logic [BYTE_W-1:0] NO_DATA     = 8'hFF;
    localparam logic [BYTE_W-1:0] PFX_E0      = 8'hE0;
    localparam logic [BYTE_W-1:0] PFX_E1      = 8'hE1;
    localparam logic [BYTE_W-1:0] PFX_F0      = 8'hF0;
    localparam logic [BYTE_W-1:0] MAX_SCAN    = 8'h83;

    localparam logic KIND_TX  = 1'b0;
    localparam logic KIND_KEY = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_RX    = 2'd0,
        OP_QUEUE = 2'd1,
        OP_QUERY = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        PS_IDLE = 2'd0,
        PS_F0   = 2'd1,
        PS_E0   = 2'd2,
        PS_E1   = 2'd3
    } prefix_t;

    typedef struct packed {
        logic             en;
        logic [KEY_W-1:0] addr;
        logic             val;
    } key_wr_t;

    typedef struct packed {
        logic              ack;
        logic              resend;
        logic              push;
        logic [BYTE_W-1:0] cmd_byte;
        logic [BYTE_W-1:0] data_byte;
    } q_ev_t;

    typedef struct packed {
        logic              send;
        logic              with_data;
        logic [BYTE_W-1:0] cmd_byte;
        logic [BYTE_W-1:0] data_byte;
    } q_send_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              awaiting;
    } q_stat_t;

    typedef struct packed {
        logic              result_kind;
        logic [BYTE_W-1:0] tx_byte;
        logic              key_is_down;
        logic              last;
    } res_t;

    localparam logic [KEY_W-1:0] SCAN_KEY_TABLE [0:131] = '{
        0, 67, 0, 63, 61, 59, 60, 88, 0, 68, 66, 64, 62, 15, 41, 0,
        0, 56, 42, 0, 29, 16, 2, 0, 0, 0, 44, 31, 30, 17, 3, 0,
        0, 46, 45, 32, 18, 5, 4, 0, 0, 57, 47, 33, 20, 19, 6, 0,
        0, 49, 48, 35, 34, 21, 7, 0, 0, 0, 50, 36, 22, 8, 9, 0,
        0, 51, 37, 23, 24, 11, 10, 0, 0, 52, 53, 38, 39, 25, 12, 0,
        0, 0, 40, 0, 26, 13, 0, 0, 58, 54, 28, 27, 0, 43, 0, 0,
        0, 0, 0, 0, 0, 0, 14, 0, 0, 79, 0, 75, 71, 0, 0, 0,
        82, 83, 80, 76, 77, 72, 1, 69, 87, 78, 81, 74, 55, 73, 70, 0,
        0, 0, 0, 65
    };

    // Codes past the end of the table map to no key.
    function automatic logic [KEY_W-1:0] scan_to_key(input logic [BYTE_W-1:0] code);
        logic [KEY_W-1:0] key;
        key = '0;
        if (code <= MAX_SCAN)
        begin
            key = SCAN_KEY_TABLE[code];
        end
        return key;
    endfunction

endpackage

// ===== hdl/ps2kb_in_if.sv =====
interface ps2kb_in_if import ps2kb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] byte_in;
    logic [BYTE_W-1:0] cmd_data;
    logic [KEY_W-1:0]  key_index;

    modport source (output valid, operation, byte_in, cmd_data, key_index, input ready);
    modport sink   (input valid, operation, byte_in, cmd_data, key_index, output ready);
endinterface

// ===== hdl/ps2kb_out_if.sv =====
interface ps2kb_out_if import ps2kb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              result_kind;
    logic [BYTE_W-1:0] tx_byte;
    logic              key_is_down;
    logic              last;

    modport source (output valid, result_kind, tx_byte, key_is_down, last, input ready);
    modport sink   (input valid, result_kind, tx_byte, key_is_down, last, output ready);
endinterface

// ===== hdl/ps2kb_scan_fsm.sv =====
module ps2kb_scan_fsm import ps2kb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              scan_en,
    input  logic [BYTE_W-1:0] code,
    output key_wr_t           key_wr
);

    prefix_t          state_reg;
    prefix_t          state_next;
    logic             is_prefix;
    logic [KEY_W-1:0] keycode;

    assign is_prefix = (code == PFX_E0) || (code == PFX_E1) || (code == PFX_F0);
    assign keycode   = scan_to_key(code);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        if (scan_en)
        begin
            case (state_reg)
                PS_E0, PS_E1:
                begin
                    // Extended sequences are not decoded; drop the byte.
                    if (!is_prefix)
                    begin
                        state_next = PS_IDLE;
                    end
                end
                PS_IDLE, PS_F0:
                begin
                    if (code == PFX_E0)
                    begin
                        state_next = PS_E0;
                    end
                    else if (code == PFX_E1)
                    begin
                        state_next = PS_E1;
                    end
                    else if (code == PFX_F0)
                    begin
                        state_next = PS_F0;
                    end
                    else
                    begin
                        state_next = PS_IDLE;
                    end
                end
                default:
                begin
                    state_next = PS_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        key_wr.en   = 1'b0;
        key_wr.addr = keycode;
        key_wr.val  = 1'b1;
        case (state_reg)
            PS_IDLE, PS_F0:
            begin
                key_wr.en  = scan_en && !is_prefix && (keycode != '0);
                key_wr.val = (state_reg != PS_F0);
            end
            default:
            begin
                key_wr.en = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/ps2kb_key_map.sv =====
module ps2kb_key_map import ps2kb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [KEY_W-1:0] rd_addr,
    input  key_wr_t          key_wr,
    output logic             key_is_down
);

    logic                 pressed_reg [KEY_SLOTS];
    logic [KEY_SLOTS-1:0] valid_reg;
    logic                 rd_bit_reg;
    logic                 rd_vld_reg;
    logic                 hit_reg;
    logic                 hit_val_reg;

    always_ff @(posedge clk)
    begin
        if (key_wr.en)
        begin
            pressed_reg[key_wr.addr] <= key_wr.val;
        end
    end

    // Entries never written since reset read as released.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (key_wr.en)
        begin
            valid_reg[key_wr.addr] <= 1'b1;
        end
    end

    // Read on request capture; a write on the same edge is forwarded.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_bit_reg  <= pressed_reg[rd_addr];
            rd_vld_reg  <= valid_reg[rd_addr];
            hit_reg     <= key_wr.en && (key_wr.addr == rd_addr);
            hit_val_reg <= key_wr.val;
        end
    end

    assign key_is_down = hit_reg ? hit_val_reg : (rd_vld_reg & rd_bit_reg);

endmodule

// ===== hdl/ps2kb_cmd_queue.sv =====
module ps2kb_cmd_queue import ps2kb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [RETRY_W-1:0] max_retries,
    input  q_ev_t              ev,
    output q_send_t            tx,
    output q_stat_t            stat
);

    logic [BYTE_W-1:0]  cmd_mem_reg  [QDEPTH];
    logic [BYTE_W-1:0]  data_mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  head_reg;
    logic [QPTR_W-1:0]  head_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic [QCNT_W-1:0]  count_popped;
    logic [RETRY_W-1:0] retry_reg;
    logic [RETRY_W-1:0] retry_next;
    logic               awaiting_reg;
    logic               awaiting_next;
    logic [RETRY_W:0]   retry_inc;
    logic               drop;
    logic               pop;
    logic               push_ok;
    logic [QPTR_W-1:0]  slot;
    logic               bypass;
    logic [BYTE_W-1:0]  head_cmd;
    logic [BYTE_W-1:0]  head_data;

    assign retry_inc = {1'b0, retry_reg} + (RETRY_W+1)'(1);
    assign drop      = ev.ack || (ev.resend && (retry_inc > {1'b0, max_retries}));
    assign pop       = drop && (count_reg != '0);
    assign push_ok   = ev.push && (count_reg != QCNT_W'(QDEPTH));
    assign slot      = head_reg + count_reg[QPTR_W-1:0];

    assign head_next    = pop ? head_reg + QPTR_W'(1) : head_reg;
    assign count_popped = count_reg - QCNT_W'(pop);
    assign count_next   = count_popped + QCNT_W'(push_ok);

    always_comb
    begin
        retry_next = retry_reg;
        if (drop)
        begin
            retry_next = '0;
        end
        else if (ev.resend)
        begin
            retry_next = retry_inc[RETRY_W-1:0];
        end
    end

    // A command pushed into an empty queue is also the head being sent.
    assign bypass    = push_ok && (count_reg == '0);
    assign head_cmd  = bypass ? ev.cmd_byte  : cmd_mem_reg[head_next];
    assign head_data = bypass ? ev.data_byte : data_mem_reg[head_next];

    always_comb
    begin
        tx.send = 1'b0;
        if ((ev.ack || ev.resend) && (count_popped != '0))
        begin
            tx.send = 1'b1;
        end
        else if (push_ok && !awaiting_reg)
        begin
            tx.send = 1'b1;
        end
        tx.with_data = (head_data != NO_DATA);
        tx.cmd_byte  = head_cmd;
        tx.data_byte = head_data;
    end

    assign awaiting_next = tx.send || (awaiting_reg && !drop);

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            cmd_mem_reg[slot]  <= ev.cmd_byte;
            data_mem_reg[slot] <= ev.data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            count_reg    <= '0;
            retry_reg    <= '0;
            awaiting_reg <= 1'b0;
        end
        else
        begin
            head_reg     <= head_next;
            count_reg    <= count_next;
            retry_reg    <= retry_next;
            awaiting_reg <= awaiting_next;
        end
    end

    assign stat.count    = count_reg;
    assign stat.awaiting = awaiting_reg;

endmodule

// ===== hdl/ps2kb_out_fifo.sv =====
module ps2kb_out_fifo import ps2kb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push0,
    input  res_t  res0,
    input  logic  push1,
    input  res_t  res1,
    output logic  room,
    ps2kb_out_if.source results
);

    res_t                 mem_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg;
    logic [OUT_PTR_W-1:0] wr_ptr_next;
    logic [OUT_PTR_W-1:0] rd_ptr_reg;
    logic [OUT_PTR_W-1:0] rd_ptr_next;
    logic [OUT_CNT_W-1:0] count_reg;
    logic [OUT_CNT_W-1:0] count_next;
    logic                 pop;
    res_t                 head;

    assign pop  = results.valid && results.ready;
    assign room = (count_reg <= OUT_CNT_W'(OUT_DEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + OUT_PTR_W'(push0) + OUT_PTR_W'(push1);
    assign rd_ptr_next = rd_ptr_reg + OUT_PTR_W'(pop);
    assign count_next  = count_reg + OUT_CNT_W'(push0) + OUT_CNT_W'(push1)
                         - OUT_CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            mem_reg[wr_ptr_reg] <= res0;
        end
        if (push1)
        begin
            mem_reg[wr_ptr_reg + OUT_PTR_W'(1)] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head                = mem_reg[rd_ptr_reg];
    assign results.valid       = (count_reg != '0);
    assign results.result_kind = head.result_kind;
    assign results.tx_byte     = head.tx_byte;
    assign results.key_is_down = head.key_is_down;
    assign results.last        = head.last;

endmodule

// ===== hdl/ps2_keyboard_host_decoder.sv =====
// Channel   Dir   Handshake      Payload
// items     in    valid/ready    operation, byte_in, cmd_data, key_index
// results   out   valid/ready    result_kind, tx_byte, key_is_down, last
// cfg       in    cfg_we         cfg_wdata (max_retries)
//
// One request is taken per cycle unless the input stalls. It is registered at the
// input, handled by one pass of logic that updates all state once the result buffer
// has room, and its results enter a four-entry buffer.
// The result side moves one result per cycle while the receiver is ready, so requests
// with two results (a command and its data byte) cannot be taken at that rate.
// Reset is asynchronous, active low. The input stalls with fewer than two free entries.
`include "assert_macros.svh"

module ps2_keyboard_host_decoder import ps2kb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    ps2kb_in_if.sink           items,
    ps2kb_out_if.source        results,
    input  logic               cfg_we,
    input  logic [RETRY_W-1:0] cfg_wdata
);

    // Retry limit for resend requests from the keyboard.
    logic [RETRY_W-1:0] max_retries_reg;

    // Input register. The valid flag is control; the payload is not reset.
    logic               in_vld_reg;
    logic               in_vld_next;
    op_t                op_reg;
    logic [BYTE_W-1:0]  byte_reg;
    logic [BYTE_W-1:0]  data_reg;

    logic               accept;
    logic               proc_fire;
    logic               out_room;

    logic               is_ack;
    logic               is_resend;
    logic               scan_en;
    logic               query;
    q_ev_t              q_ev;
    q_send_t            q_tx;
    q_stat_t            q_stat;
    key_wr_t            key_wr;
    logic               key_is_down;

    logic               push0;
    logic               push1;
    res_t               res0;
    res_t               res1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_retries_reg <= MAX_RETRIES_RST;
        end
        else if (cfg_we)
        begin
            max_retries_reg <= cfg_wdata;
        end
    end

    // The held request is processed whenever the result buffer can take
    // two more results, and a new request may enter in the same cycle.
    assign proc_fire   = in_vld_reg && out_room;
    assign items.ready = !in_vld_reg || proc_fire;
    assign accept      = items.valid && items.ready;
    assign in_vld_next = accept || (in_vld_reg && !proc_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op_t'(items.operation);
            byte_reg <= items.byte_in;
            data_reg <= items.cmd_data;
        end
    end

    // Route the request. Received bytes split into acknowledge, resend
    // and scan traffic; the unused operation code does nothing.
    always_comb
    begin
        is_ack    = 1'b0;
        is_resend = 1'b0;
        scan_en   = 1'b0;
        query     = 1'b0;
        q_ev.push = 1'b0;
        case (op_reg)
            OP_RX:
            begin
                is_ack    = proc_fire && (byte_reg == ACK_BYTE);
                is_resend = proc_fire && (byte_reg == RESEND_BYTE);
                scan_en   = proc_fire && (byte_reg != ACK_BYTE) && (byte_reg != RESEND_BYTE);
            end
            OP_QUEUE:
            begin
                q_ev.push = proc_fire;
            end
            OP_QUERY:
            begin
                query = proc_fire;
            end
            default:
            begin
                query = 1'b0;
            end
        endcase
        q_ev.ack       = is_ack;
        q_ev.resend    = is_resend;
        q_ev.cmd_byte  = byte_reg;
        q_ev.data_byte = data_reg;
    end

    ps2kb_cmd_queue u_cmd_queue
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .max_retries (max_retries_reg),
        .ev          (q_ev),
        .tx          (q_tx),
        .stat        (q_stat)
    );

    ps2kb_scan_fsm u_scan_fsm
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .scan_en (scan_en),
        .code    (byte_reg),
        .key_wr  (key_wr)
    );

    // The key bitmap is read when a request is captured, so the bit is
    // ready by the time the query is processed.
    ps2kb_key_map u_key_map
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_en       (accept),
        .rd_addr     (items.key_index),
        .key_wr      (key_wr),
        .key_is_down (key_is_down)
    );

    // Build up to two results. A send gives the command byte and, unless
    // the data slot is empty, a second result carrying the data byte.
    always_comb
    begin
        push0            = 1'b0;
        push1            = 1'b0;
        res0.result_kind = KIND_TX;
        res0.tx_byte     = q_tx.cmd_byte;
        res0.key_is_down = 1'b0;
        res0.last        = !q_tx.with_data;
        res1.result_kind = KIND_TX;
        res1.tx_byte     = q_tx.data_byte;
        res1.key_is_down = 1'b0;
        res1.last        = 1'b1;
        if (query)
        begin
            push0            = 1'b1;
            res0.result_kind = KIND_KEY;
            res0.tx_byte     = '0;
            res0.key_is_down = key_is_down;
            res0.last        = 1'b1;
        end
        else if (q_tx.send)
        begin
            push0 = 1'b1;
            push1 = q_tx.with_data;
        end
    end

    ps2kb_out_fifo u_out_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push0   (push0),
        .res0    (res0),
        .push1   (push1),
        .res1    (res1),
        .room    (out_room),
        .results (results)
    );

    // An empty command queue never leaves the host waiting for an acknowledge.
    `PS2KB_ASSERT(a_empty_not_awaiting, clk, rst_n, (q_stat.count == '0) |-> !q_stat.awaiting, "awaiting acknowledge with empty queue")
    // The command queue never holds more than its depth.
    `PS2KB_ASSERT(a_queue_bound, clk, rst_n, q_stat.count <= QCNT_W'(QDEPTH), "command queue overflow")
    // A processed query yields exactly one result, marked last.
    `PS2KB_ASSERT(a_query_single, clk, rst_n, (proc_fire && (op_reg == OP_QUERY)) |-> (push0 && !push1 && res0.last), "query did not give a single final result")

endmodule

// ===== tb/sv/ps2_keyboard_host_decoder_test.sv =====
`timescale 1ns / 1ps

// This bench runs the PS/2 keyboard host decoder through received bytes, queued
// commands and key queries. It predicts the transmit bytes and key state replies
// with its own model of the block and compares every result that comes out.
module ps2_keyboard_host_decoder_test import ps2kb_pkg::*;;

    // Operation code that the block does not use. It must be ignored.
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    // Cycles that the block may still be busy after its last result has left.
    localparam int SETTLE_CYCLES = 8;

    // Length of the long receiver hold-off that fills the result buffer.
    localparam int LONG_HOLD = 300;

    // Model of the host decoder. It mirrors the prefix machine, the pressed-key
    // bitmap and the command ring, and it keeps the results that the block still
    // owes in arrival order.
    class key_host_mirror;
        localparam logic [KEY_W-1:0] KEY_OF_SCAN [0:131] = '{
            0, 67, 0, 63, 61, 59, 60, 88, 0, 68, 66, 64, 62, 15, 41, 0,
            0, 56, 42, 0, 29, 16, 2, 0, 0, 0, 44, 31, 30, 17, 3, 0,
            0, 46, 45, 32, 18, 5, 4, 0, 0, 57, 47, 33, 20, 19, 6, 0,
            0, 49, 48, 35, 34, 21, 7, 0, 0, 0, 50, 36, 22, 8, 9, 0,
            0, 51, 37, 23, 24, 11, 10, 0, 0, 52, 53, 38, 39, 25, 12, 0,
            0, 0, 40, 0, 26, 13, 0, 0, 58, 54, 28, 27, 0, 43, 0, 0,
            0, 0, 0, 0, 0, 0, 14, 0, 0, 79, 0, 75, 71, 0, 0, 0,
            82, 83, 80, 76, 77, 72, 1, 69, 87, 78, 81, 74, 55, 73, 70, 0,
            0, 0, 0, 65
        };

        logic [RETRY_W-1:0] retry_limit;
        prefix_t            prefix;
        bit [KEY_SLOTS-1:0] keys_down;
        logic [BYTE_W-1:0]  cmd_ring  [QDEPTH];
        logic [BYTE_W-1:0]  data_ring [QDEPTH];
        int                 ring_head;
        int                 ring_fill;
        int                 resend_count;
        bit                 ack_pending;
        res_t               pending_replies [$];
        int                 mismatches;

        function new();
            retry_limit = MAX_RETRIES_RST;
            prefix = PS_IDLE;
            keys_down = '0;
            ring_head = 0;
            ring_fill = 0;
            resend_count = 0;
            ack_pending = 1'b0;
            mismatches = 0;
        endfunction

        function void set_retry_limit(logic [RETRY_W-1:0] value);
            retry_limit = value;
        endfunction

        function void owe_tx(logic [BYTE_W-1:0] value);
            res_t r;
            r.result_kind = KIND_TX;
            r.tx_byte = value;
            r.key_is_down = 1'b0;
            r.last = 1'b0;
            pending_replies.push_back(r);
        endfunction

        // The head command goes out, then its data byte unless there is none.
        function void send_head();
            if (ring_fill == 0)
                return;
            owe_tx(cmd_ring[ring_head]);
            if (data_ring[ring_head] != NO_DATA)
                owe_tx(data_ring[ring_head]);
            ack_pending = 1'b1;
        endfunction

        function void pop_head();
            if (ring_fill > 0)
            begin
                ring_head = (ring_head + 1) % QDEPTH;
                ring_fill--;
            end
            resend_count = 0;
            ack_pending = 1'b0;
        endfunction

        function void scan_code(logic [BYTE_W-1:0] code);
            logic             is_prefix;
            logic [KEY_W-1:0] keycode;
            is_prefix = (code == PFX_E0) || (code == PFX_E1) || (code == PFX_F0);
            // Extended codes are not decoded: the byte after the prefixes is dropped.
            if (prefix == PS_E0 || prefix == PS_E1)
            begin
                if (!is_prefix)
                    prefix = PS_IDLE;
                return;
            end
            if (code == PFX_E0)
                prefix = PS_E0;
            else if (code == PFX_E1)
                prefix = PS_E1;
            else if (code == PFX_F0)
                prefix = PS_F0;
            else
            begin
                keycode = (code <= MAX_SCAN) ? KEY_OF_SCAN[code] : '0;
                if (keycode != '0)
                    keys_down[keycode] = (prefix != PS_F0);
                prefix = PS_IDLE;
            end
        endfunction

        function void take_request(logic [OP_W-1:0] op, logic [BYTE_W-1:0] code,
                                   logic [BYTE_W-1:0] data, logic [KEY_W-1:0] key);
            int   owed_before;
            int   slot;
            res_t r;
            owed_before = pending_replies.size();
            case (op)
                OP_RX:
                begin
                    if (code == ACK_BYTE)
                    begin
                        pop_head();
                        send_head();
                    end
                    else if (code == RESEND_BYTE)
                    begin
                        if (resend_count + 1 > int'(retry_limit))
                            pop_head();
                        else
                            resend_count++;
                        send_head();
                    end
                    else
                        scan_code(code);
                end
                OP_QUEUE:
                begin
                    if (ring_fill < QDEPTH)
                    begin
                        slot = (ring_head + ring_fill) % QDEPTH;
                        cmd_ring[slot] = code;
                        data_ring[slot] = data;
                        ring_fill++;
                        if (!ack_pending)
                            send_head();
                    end
                end
                OP_QUERY:
                begin
                    r.result_kind = KIND_KEY;
                    r.tx_byte = '0;
                    r.key_is_down = keys_down[key];
                    r.last = 1'b0;
                    pending_replies.push_back(r);
                end
                default:
                    ;
            endcase
            // The final result of a request carries the last flag.
            if (pending_replies.size() > owed_before)
            begin
                r = pending_replies.pop_back();
                r.last = 1'b1;
                pending_replies.push_back(r);
            end
        endfunction

        function void report_field(string field, logic [BYTE_W-1:0] want,
                                   logic [BYTE_W-1:0] got);
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
        endfunction

        function void compare_reply(res_t got);
            res_t want;
            if (pending_replies.size() == 0)
            begin
                mismatches++;
                $display("%0t: result expected none, got kind %0h byte %0h down %0h last %0h",
                         $time, got.result_kind, got.tx_byte, got.key_is_down, got.last);
                return;
            end
            want = pending_replies.pop_front();
            if (got.result_kind !== want.result_kind)
                report_field("result_kind", want.result_kind, got.result_kind);
            if (got.tx_byte !== want.tx_byte)
                report_field("tx_byte", want.tx_byte, got.tx_byte);
            if (got.key_is_down !== want.key_is_down)
                report_field("key_is_down", want.key_is_down, got.key_is_down);
            if (got.last !== want.last)
                report_field("last", want.last, got.last);
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we;
    logic [RETRY_W-1:0] cfg_wdata;

    ps2kb_in_if  items_ch ();
    ps2kb_out_if results_ch ();

    key_host_mirror sb;

    // Pacing controls. When a steady flag is set, that side runs with no gaps.
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    // Set by the stimulus to make the result side hold off for a long stretch.
    bit hold_long = 1'b0;
    int items_sent = 0;

    ps2_keyboard_host_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items_ch),
        .results   (results_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Offer one request and wait until the block takes it. The valid line is only
    // lowered when a gap is drawn, so a back-to-back request never sees valid drop
    // and rise within the same time step. The model is told about the request at
    // the edge where the handshake completes.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] code,
                                input logic [BYTE_W-1:0] data, input logic [KEY_W-1:0] key);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            items_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        items_ch.valid     <= 1'b1;
        items_ch.operation <= op;
        items_ch.byte_in   <= code;
        items_ch.cmd_data  <= data;
        items_ch.key_index <= key;
        @(posedge clk);
        while (items_ch.ready !== 1'b1)
            @(posedge clk);
        sb.take_request(op, code, data, key);
        items_sent++;
    endtask

    // Fields that the operation does not use are filled with random values so
    // that their bits toggle too.
    task automatic rx(input logic [BYTE_W-1:0] code);
        send_request(OP_RX, code, BYTE_W'($urandom), KEY_W'($urandom));
    endtask

    task automatic queue_cmd(input logic [BYTE_W-1:0] code, input logic [BYTE_W-1:0] data);
        send_request(OP_QUEUE, code, data, KEY_W'($urandom));
    endtask

    task automatic query(input logic [KEY_W-1:0] key);
        send_request(OP_QUERY, BYTE_W'($urandom), BYTE_W'($urandom), key);
    endtask

    // Stop offering requests, wait until every owed result has been taken, and
    // then give the block time to finish requests that produce nothing.
    task automatic drain_results();
        items_ch.valid <= 1'b0;
        while (sb.pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The register is only written while the block is idle.
    task automatic write_retry_limit(input logic [RETRY_W-1:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_retry_limit(value);
    endtask

    // A make or break of a key as a keyboard sends it, sometimes behind an
    // extended prefix. Most codes come from the table range, a few are any byte.
    task automatic key_event();
        logic [BYTE_W-1:0] code;
        int                form;
        code = ($urandom_range(0, 7) == 0) ? BYTE_W'($urandom)
                                            : BYTE_W'($urandom_range(0, int'(MAX_SCAN)));
        form = $urandom_range(0, 9);
        if (form >= 5 && form <= 7)
            rx(PFX_F0);
        else if (form == 8)
        begin
            rx(PFX_E0);
            if ($urandom_range(0, 1) == 1)
                rx(PFX_F0);
        end
        else if (form == 9)
            rx(PFX_E1);
        rx(code);
    endtask

    // Random traffic: mostly well-formed key sequences, command traffic with
    // acknowledges and resend requests, queries, and some raw noise.
    task automatic random_traffic(input int count);
        int target;
        int pick;
        target = items_sent + count;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 39) == 0)
                tx_steady = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 25)
                key_event();
            else if (pick < 45)
                query(($urandom_range(0, 3) == 0) ? KEY_W'($urandom)
                                                  : KEY_W'($urandom_range(0, 90)));
            else if (pick < 65)
                queue_cmd(BYTE_W'($urandom),
                          ($urandom_range(0, 1) == 0) ? NO_DATA : BYTE_W'($urandom));
            else if (pick < 78)
                rx(ACK_BYTE);
            else if (pick < 88)
                rx(RESEND_BYTE);
            else
                send_request(OP_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                             KEY_W'($urandom));
        end
    endtask

    // Result side. It draws a stall before every result, honors a long hold-off
    // when the stimulus asks for one, and checks each result it takes. The ready
    // line gets at most one assignment in any time step.
    initial
    begin : result_sink
        int   gap;
        int   taken;
        res_t got;
        taken = 0;
        results_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_long)
            begin
                gap = LONG_HOLD;
                hold_long = 1'b0;
            end
            else
                gap = rx_steady ? 0 : $urandom_range(0, 16);
            if (gap > 0)
            begin
                results_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            results_ch.ready <= 1'b1;
            @(posedge clk);
            while (results_ch.valid !== 1'b1)
                @(posedge clk);
            got.result_kind = results_ch.result_kind;
            got.tx_byte     = results_ch.tx_byte;
            got.key_is_down = results_ch.key_is_down;
            got.last        = results_ch.last;
            sb.compare_reply(got);
            taken++;
            if (taken % 64 == 0)
                rx_steady = ($urandom_range(0, 3) == 0);
        end
    end

    // Stimulus and the final verdict.
    initial
    begin : stimulus
        int round;
        sb = new();
        items_ch.valid     <= 1'b0;
        items_ch.operation <= OP_RX;
        items_ch.byte_in   <= '0;
        items_ch.cmd_data  <= '0;
        items_ch.key_index <= '0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with the retry limit at its reset value.
        // The lowest and highest keycodes start released.
        query('0);
        query('1);
        // A make followed by a break with a doubled break prefix.
        rx(8'h1C);
        query(7'd30);
        rx(PFX_F0);
        rx(PFX_F0);
        rx(8'h1C);
        query(7'd30);
        // The last code in the table, pressed and then released.
        rx(MAX_SCAN);
        query(7'd65);
        rx(PFX_F0);
        rx(MAX_SCAN);
        query(7'd65);
        // A code past the table, a code that maps to no key, and the top byte.
        rx(MAX_SCAN + 8'd1);
        rx(8'h00);
        rx(8'hFF);
        // Extended codes are dropped, and prefixes inside an extended
        // sequence keep the machine where it is.
        rx(PFX_E0);
        rx(8'h75);
        query(7'd72);
        rx(PFX_E1);
        rx(PFX_E0);
        rx(PFX_F0);
        rx(8'h14);
        // A command with data, then one without data that waits for the first
        // to be acknowledged, a resend of it, and acknowledges until the queue
        // is empty. A resend on an empty queue sends nothing.
        queue_cmd(8'hED, 8'h02);
        queue_cmd(8'hF4, NO_DATA);
        rx(RESEND_BYTE);
        rx(ACK_BYTE);
        rx(RESEND_BYTE);
        rx(ACK_BYTE);
        rx(ACK_BYTE);
        rx(RESEND_BYTE);
        send_request(OP_SPARE, '1, '1, '1);
        drain_results();

        // No retries at all: the first resend request drops the head.
        write_retry_limit(4'd0);
        queue_cmd(8'hFF, 8'h00);
        rx(RESEND_BYTE);
        rx(RESEND_BYTE);
        random_traffic(300);
        drain_results();

        // The largest retry limit: fifteen resend requests are honored and the sixteenth drops
        // the head, then a run of commands overfills the queue.
        write_retry_limit(4'd15);
        tx_steady = 1'b0;
        queue_cmd(8'hF3, 8'h20);
        repeat (17) rx(RESEND_BYTE);
        repeat (18) queue_cmd(BYTE_W'($urandom), BYTE_W'($urandom));
        random_traffic(300);
        drain_results();

        // Back pressure: the result side holds off for a long stretch while
        // queries keep coming back to back, so the result buffer fills and the
        // input stalls. Then the sender waits for everything to come out.
        hold_long = 1'b1;
        tx_steady = 1'b1;
        repeat (40) query(KEY_W'($urandom));
        tx_steady = 1'b0;
        drain_results();

        write_retry_limit(4'd1);
        random_traffic(300);
        drain_results();

        for (round = 0; round < 3; round++)
        begin
            write_retry_limit(RETRY_W'($urandom));
            random_traffic(200);
            drain_results();
        end

        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog for a block that hangs. The bound is far above the slowest
    // correct run, with every gap and stall at its longest.
    initial
    begin : watchdog
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
